// ===== hdl/ngga_pkg.sv =====
// Shared types and constants for the GGA sentence parser.
`timescale 1ns / 1ps
`default_nettype none
package ngga_pkg;

  localparam int unsigned FracW = 20;

  // One token from the byte front end to the field back end.
  typedef struct packed {
    logic             last;     // line end: finish field, then close record
    logic             emit;     // line holds enough fields for a record
    logic [3:0]       fnum;
    logic [31:0]      int_acc;
    logic [FracW-1:0] frac;
    logic [2:0]       fcnt;
    logic             neg;
    logic [3:0]       hemi;     // lat valid, lat neg, lon valid, lon neg
  } tok_t;

  localparam logic [3:0] FldTime = 4'd1;
  localparam logic [3:0] FldLat  = 4'd2;
  localparam logic [3:0] FldNs   = 4'd3;
  localparam logic [3:0] FldLon  = 4'd4;
  localparam logic [3:0] FldEw   = 4'd5;
  localparam logic [3:0] FldFix  = 4'd6;
  localparam logic [3:0] FldSats = 4'd7;
  localparam logic [3:0] FldHdop = 4'd8;
  localparam logic [3:0] FldAlt  = 4'd9;

  function automatic logic [FracW-1:0] pow10(input logic [2:0] e);
    logic [FracW-1:0] r;
    case (e)
      3'd0: r = 20'd1;
      3'd1: r = 20'd10;
      3'd2: r = 20'd100;
      3'd3: r = 20'd1000;
      3'd4: r = 20'd10000;
      3'd5: r = 20'd100000;
      3'd6: r = 20'd1000000;
      default: r = 20'd0;
    endcase
    return r;
  endfunction

  // Fraction digits kept per field; d is the minute fraction digit count.
  function automatic logic [2:0] kept_digits(input logic [3:0] f, input logic [2:0] d);
    logic [2:0] r;
    case (f)
      FldTime: r = 3'd3;
      FldLat:  r = d;
      FldLon:  r = d;
      FldHdop: r = 3'd2;
      FldAlt:  r = 3'd1;
      default: r = 3'd0;
    endcase
    return r;
  endfunction

endpackage
`default_nettype wire

// ===== hdl/ngga_front.sv =====
// Byte front end: line framing, header match, field split and digit accumulation.
`timescale 1ns / 1ps
`default_nettype none
module ngga_front import ngga_pkg::*; #(
  parameter int LINE_MAX = 128,
  parameter int MINUTE_FRACTION_DIGITS = 5
) (
  input  wire logic       clk_i,
  input  wire logic       rst_ni,
  input  wire logic       take_i,
  input  wire logic [7:0] byte_i,
  output logic            push_o,
  output tok_t            tok_o
);

  localparam int LenW = $clog2(LINE_MAX);
  localparam logic [LenW-1:0] LenLim = LenW'(LINE_MAX - 1);
  localparam logic [2:0] MinD = 3'(MINUTE_FRACTION_DIGITS);
  localparam logic [2:0] HdrDone = 3'd6;
  localparam logic [2:0] HdrFail = 3'd7;

  typedef enum logic [1:0] {PH_START, PH_INT, PH_FRAC, PH_STOP} phase_e;

  logic [LenW-1:0] len_q, len_d;
  logic [2:0]  hdr_q, hdr_d;
  logic [3:0]  fnum_q, fnum_d;
  logic [31:0] int_q, int_d;
  logic [FracW-1:0] frac_q, frac_d;
  logic [2:0]  fcnt_q, fcnt_d;
  phase_e      phase_q, phase_d;
  logic        neg_q, neg_d;
  logic [3:0]  hemi_q, hemi_d;

  logic        is_eol, is_digit, hdr_ok;
  logic [35:0] int_wide;
  logic [3:0]  dig;
  logic [1:0]  hbits;

  function automatic logic hdr_byte(input logic [2:0] p, input logic [7:0] c);
    logic r;
    case (p)
      3'd0: r = (c == "$");
      3'd1: r = (c == "G");
      3'd2: r = (c == "N") || (c == "P");
      3'd3: r = (c == "G");
      3'd4: r = (c == "G");
      3'd5: r = (c == "A");
      default: r = 1'b0;
    endcase
    return r;
  endfunction

  always_comb begin
    len_d = len_q; hdr_d = hdr_q; fnum_d = fnum_q; int_d = int_q; frac_d = frac_q;
    fcnt_d = fcnt_q; phase_d = phase_q; neg_d = neg_q; hemi_d = hemi_q;
    push_o = 1'b0;
    is_eol = (byte_i == 8'h0d) || (byte_i == 8'h0a);
    is_digit = (byte_i >= "0") && (byte_i <= "9");
    dig = byte_i[3:0];
    int_wide = {4'd0, int_q} * 36'd10 + {32'd0, dig};
    hdr_ok = hdr_byte(3'(len_q), byte_i);
    hbits = 2'b00;
    if ((byte_i == "N") || (byte_i == "E")) hbits = 2'b01;
    else if ((byte_i == "S") || (byte_i == "W")) hbits = 2'b11;
    tok_o.last = is_eol;
    tok_o.emit = (fnum_q >= FldAlt);
    tok_o.fnum = fnum_q;
    tok_o.int_acc = int_q;
    tok_o.frac = frac_q;
    tok_o.fcnt = fcnt_q;
    tok_o.neg = neg_q;
    tok_o.hemi = hemi_q;
    if (take_i) begin
      if (is_eol) begin
        if (len_q != '0) begin
          push_o = (hdr_q == HdrDone);
          len_d = '0; hdr_d = '0; fnum_d = '0; hemi_d = '0;
          int_d = '0; frac_d = '0; fcnt_d = '0; phase_d = PH_START; neg_d = 1'b0;
        end
      end else if (len_q < LenLim) begin
        len_d = len_q + 1'b1;
        if (len_q < LenW'(6)) begin
          if (hdr_q == 3'(len_q)) hdr_d = hdr_ok ? 3'(len_q) + 3'd1 : HdrFail;
        end else if (hdr_q == HdrDone) begin
          if (byte_i == ",") begin
            // Forward only fields that carry a result.
            push_o = (fnum_q == FldTime) || (fnum_q == FldLat) || (fnum_q == FldLon) ||
                     (fnum_q == FldFix) || (fnum_q == FldSats) || (fnum_q == FldHdop) ||
                     (fnum_q == FldAlt);
            if (fnum_q != 4'd15) fnum_d = fnum_q + 4'd1;
            int_d = '0; frac_d = '0; fcnt_d = '0; phase_d = PH_START; neg_d = 1'b0;
          end else if ((fnum_q == FldNs) || (fnum_q == FldEw)) begin
            if (phase_q == PH_START) begin
              if (fnum_q == FldNs) hemi_d[1:0] = hbits;
              else hemi_d[3:2] = hbits;
              phase_d = PH_STOP;
            end
          end else if (phase_q != PH_STOP) begin
            if (is_digit) begin
              if (phase_q == PH_FRAC) begin
                if (fcnt_q < kept_digits(fnum_q, MinD)) begin
                  frac_d = FracW'(frac_q * FracW'(10)) + FracW'(dig);
                  fcnt_d = fcnt_q + 3'd1;
                end
              end else begin
                int_d = (int_wide[35:32] != 4'd0) ? 32'hffff_ffff : int_wide[31:0];
                phase_d = PH_INT;
              end
            end else if ((phase_q == PH_START) && ((byte_i == "-") || (byte_i == "+"))) begin
              neg_d = (byte_i == "-");
              phase_d = PH_INT;
            end else if (((phase_q == PH_START) || (phase_q == PH_INT)) && (byte_i == ".")) begin
              phase_d = PH_FRAC;
            end else begin
              phase_d = PH_STOP;
            end
          end
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      len_q <= '0; hdr_q <= '0; fnum_q <= '0; int_q <= '0; frac_q <= '0;
      fcnt_q <= '0; phase_q <= PH_START; neg_q <= 1'b0; hemi_q <= '0;
    end else begin
      len_q <= len_d; hdr_q <= hdr_d; fnum_q <= fnum_d; int_q <= int_d; frac_q <= frac_d;
      fcnt_q <= fcnt_d; phase_q <= phase_d; neg_q <= neg_d; hemi_q <= hemi_d;
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ngga_fifo.sv =====
// Short token queue between front end and back end.
`timescale 1ns / 1ps
`default_nettype none
module ngga_fifo import ngga_pkg::*; (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic push_i,
  input  tok_t      tok_i,
  output logic      full_o,
  input  wire logic pop_i,
  output logic      valid_o,
  output tok_t      tok_o
);

  localparam int Depth = 4;
  localparam int PtrW = $clog2(Depth);

  tok_t mem_q [Depth];
  logic [PtrW-1:0] wr_q, rd_q;
  logic [PtrW:0]   cnt_q;
  logic do_pop;

  assign full_o  = (cnt_q == (PtrW+1)'(Depth));
  assign valid_o = (cnt_q != '0);
  assign tok_o   = mem_q[rd_q];
  assign do_pop  = pop_i && valid_o;

  always_ff @(posedge clk_i) begin
    if (push_i) mem_q[wr_q] <= tok_i;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q <= '0; rd_q <= '0; cnt_q <= '0;
    end else begin
      if (push_i) wr_q <= wr_q + 1'b1;
      if (do_pop) rd_q <= rd_q + 1'b1;
      cnt_q <= cnt_q + (PtrW+1)'(push_i) - (PtrW+1)'(do_pop);
    end
  end

endmodule
`default_nettype wire

// ===== hdl/ngga_back.sv =====
// Back end: field value pipeline, coordinate conversion and record register.
`timescale 1ns / 1ps
`default_nettype none
module ngga_back import ngga_pkg::*; #(
  parameter int MINUTE_FRACTION_DIGITS = 5
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         in_valid_i,
  input  tok_t              in_tok_i,
  output logic              pop_o,
  output logic              out_valid_o,
  input  wire logic         out_ready_i,
  output logic [17:0]       utc_hhmmss_o,
  output logic [9:0]        utc_millis_o,
  output logic signed [30:0] latitude_e7_o,
  output logic signed [31:0] longitude_e7_o,
  output logic [3:0]        fix_ind_o,
  output logic [6:0]        satellite_count_o,
  output logic [16:0]       hdop_centi_o,
  output logic signed [20:0] altitude_dm_o
);

  localparam logic [2:0] MinD = 3'(MINUTE_FRACTION_DIGITS);
  localparam logic [19:0] PowD = pow10(MinD);
  localparam logic [19:0] Pow7D = pow10(3'd7 - MinD);
  localparam logic [30:0] M25 = 31'd1374389534;   // floor(2^35 / 25)
  localparam logic [30:0] M60 = 31'd1145324612;   // floor(2^36 / 60)
  localparam logic [50:0] LatLim = 51'd900000000;
  localparam logic [50:0] LonLim = 51'd1800000000;

  logic en;
  assign en = !(out_valid_o && !out_ready_i);
  assign pop_o = en;

  // stage 1: reciprocal product for /100, padded fraction
  logic v1_q; tok_t t1_q; logic [60:0] p1_q; logic [19:0] pad1_q;
  logic [2:0] k1, n1;
  // stage 2
  logic v2_q; tok_t t2_q; logic [19:0] pad2_q; logic [25:0] q2_q; logic [7:0] r2_q;
  // stage 3
  logic v3_q; tok_t t3_q; logic [19:0] pad3_q; logic [26:0] mins3_q; logic [49:0] dege3_q;
  logic [25:0] deg3; logic [6:0] mod3;
  // stage 4
  logic v4_q; tok_t t4_q; logic [19:0] pad4_q; logic [49:0] dege4_q; logic [29:0] x4_q;
  // stage 5
  logic v5_q; tok_t t5_q; logic [19:0] pad5_q; logic [49:0] dege5_q; logic [29:0] x5_q;
  logic [60:0] p5_q;
  // stage 6
  logic v6_q; tok_t t6_q; logic [19:0] pad6_q; logic [49:0] dege6_q; logic [23:0] q6_q;
  logic [24:0] q60; logic [30:0] m60; logic [6:0] r60;

  always_comb begin
    k1 = kept_digits(in_tok_i.fnum, MinD);
    n1 = (in_tok_i.fcnt > k1) ? k1 : in_tok_i.fcnt;
    deg3 = (r2_q >= 8'd100) ? q2_q + 26'd1 : q2_q;
    mod3 = (r2_q >= 8'd100) ? 7'(r2_q - 8'd100) : r2_q[6:0];
    q60 = p5_q[60:36];
    m60 = 31'(q60) * 31'd60;
    r60 = 7'(31'(x5_q) - m60);
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      t1_q <= in_tok_i;
      p1_q <= 61'(in_tok_i.int_acc[31:2]) * 61'(M25);
      pad1_q <= 20'(in_tok_i.frac * pow10(k1 - n1));
      t2_q <= t1_q; pad2_q <= pad1_q;
      q2_q <= p1_q[60:35];
      r2_q <= 8'(t1_q.int_acc - 32'(33'(p1_q[60:35]) * 33'd100));
      t3_q <= t2_q; pad3_q <= pad2_q;
      mins3_q <= 27'(mod3) * 27'(PowD) + 27'(pad2_q);
      dege3_q <= 50'(deg3) * 50'd10000000;
      t4_q <= t3_q; pad4_q <= pad3_q; dege4_q <= dege3_q;
      x4_q <= 30'(57'(mins3_q) * 57'(Pow7D) + 57'd30);
      t5_q <= t4_q; pad5_q <= pad4_q; dege5_q <= dege4_q; x5_q <= x4_q;
      p5_q <= 61'(x4_q) * 61'(M60);
      t6_q <= t5_q; pad6_q <= pad5_q; dege6_q <= dege5_q;
      q6_q <= (r60 >= 7'd60) ? 24'(q60 + 25'd1) : 24'(q60);
    end
  end

  // stage 7: field results and record
  logic [17:0] tim_q, tim_d; logic [9:0] ms_q, ms_d;
  logic [31:0] lat_q, lat_d, lon_q, lon_d;
  logic [3:0] fix_q, fix_d; logic [6:0] sat_q, sat_d;
  logic [16:0] hd_q, hd_d; logic [20:0] alt_q, alt_d;
  logic [31:0] ip; logic [50:0] mag, magc; logic [31:0] cval;
  logic [20:0] altv; logic [16:0] hdv; logic [31:0] lat_s, lon_s;
  logic load;

  always_comb begin
    tim_d = tim_q; ms_d = ms_q; lat_d = lat_q; lon_d = lon_q;
    fix_d = fix_q; sat_d = sat_q; hd_d = hd_q; alt_d = alt_q;
    ip = t6_q.neg ? 32'd0 : t6_q.int_acc;
    mag = 51'(dege6_q) + 51'(q6_q);
    magc = mag;
    if ((t6_q.fnum == FldLat) && (mag > LatLim)) magc = LatLim;
    if ((t6_q.fnum == FldLon) && (mag > LonLim)) magc = LonLim;
    cval = t6_q.neg ? 32'd0 - magc[31:0] : magc[31:0];
    // A minus sign drops the fraction as well as the integer part.
    hdv = (ip >= 32'd1000) ? 17'd99999 :
          17'(ip[9:0]) * 17'd100 + 17'(t6_q.neg ? 20'd0 : pad6_q);
    if (t6_q.int_acc > 32'd100000) altv = t6_q.neg ? 21'd0 - 21'd100000 : 21'd1000000;
    else begin
      altv = 21'(t6_q.int_acc[16:0]) * 21'd10 + 21'(pad6_q);
      if (t6_q.neg) altv = 21'd0 - ((altv > 21'd100000) ? 21'd100000 : altv);
      else if (altv > 21'd1000000) altv = 21'd1000000;
    end
    if (v6_q) begin
      case (t6_q.fnum)
        FldTime: begin
          tim_d = (ip > 32'd235960) ? 18'd235960 : ip[17:0];
          ms_d = t6_q.neg ? 10'd0 : pad6_q[9:0];
        end
        FldLat:  lat_d = cval;
        FldLon:  lon_d = cval;
        FldFix:  fix_d = (ip > 32'd9) ? 4'd9 : ip[3:0];
        FldSats: sat_d = (ip > 32'd99) ? 7'd99 : ip[6:0];
        FldHdop: hd_d = hdv;
        FldAlt:  alt_d = altv;
        default: ;
      endcase
    end
    lat_s = t6_q.hemi[0] ? (t6_q.hemi[1] ? 32'd0 - lat_d : lat_d) : 32'd0;
    lon_s = t6_q.hemi[2] ? (t6_q.hemi[3] ? 32'd0 - lon_d : lon_d) : 32'd0;
    load = v6_q && t6_q.last && t6_q.emit;
  end

  always_ff @(posedge clk_i) begin
    if (en && load) begin
      utc_hhmmss_o <= tim_d; utc_millis_o <= ms_d;
      latitude_e7_o <= lat_s[30:0]; longitude_e7_o <= lon_s;
      fix_ind_o <= fix_d; satellite_count_o <= sat_d;
      hdop_centi_o <= hd_d; altitude_dm_o <= alt_d;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0; v2_q <= 1'b0; v3_q <= 1'b0; v4_q <= 1'b0; v5_q <= 1'b0; v6_q <= 1'b0;
      out_valid_o <= 1'b0;
      tim_q <= '0; ms_q <= '0; lat_q <= '0; lon_q <= '0;
      fix_q <= '0; sat_q <= '0; hd_q <= '0; alt_q <= '0;
    end else begin
      if (en) begin
        v1_q <= in_valid_i; v2_q <= v1_q; v3_q <= v2_q;
        v4_q <= v3_q; v5_q <= v4_q; v6_q <= v5_q;
        if (v6_q && t6_q.last) begin
          tim_q <= '0; ms_q <= '0; lat_q <= '0; lon_q <= '0;
          fix_q <= '0; sat_q <= '0; hd_q <= '0; alt_q <= '0;
        end else begin
          tim_q <= tim_d; ms_q <= ms_d; lat_q <= lat_d; lon_q <= lon_d;
          fix_q <= fix_d; sat_q <= sat_d; hd_q <= hd_d; alt_q <= alt_d;
        end
        out_valid_o <= load;
      end
    end
  end

endmodule
`default_nettype wire

// ===== hdl/nmea_gga_sentence_parser.sv =====
// Top level of the NMEA GGA sentence parser: front end, token queue, back end.
// Throughput: one byte per cycle; input stalls only while the record register is
//   held by a stalled consumer and the four-entry token queue has filled.
// Path: after the CR or LF byte is taken, a record passes the queue write, six conversion
//   stages, then the record register; a stalled consumer holds the pipeline.
// Reset: rst_ni clears line state, queue pointers, pipeline valids and field results.
`timescale 1ns / 1ps
`default_nettype none
module nmea_gga_sentence_parser import ngga_pkg::*; #(
  parameter int LINE_MAX = 128,
  parameter int MINUTE_FRACTION_DIGITS = 5
) (
  input  wire logic         clk_i,
  input  wire logic         rst_ni,
  input  wire logic         s_axis_tvalid,
  output logic              s_axis_tready,
  input  wire logic [7:0]   s_axis_tdata,   // [7:0] rx_byte
  output logic              m_axis_tvalid,
  input  wire logic         m_axis_tready,
  // [17:0] utc_hhmmss, [27:18] utc_millis, [58:28] latitude_e7, [90:59] longitude_e7,
  // [94:91] fix indicator, [101:95] satellite_count, [118:102] hdop_centi,
  // [139:119] altitude_dm, [143:140] zero
  output logic [143:0]      m_axis_tdata
);

  logic take, push, full, qvalid, pop;
  tok_t ftok, qtok;
  logic [17:0] hhmmss; logic [9:0] millis;
  logic signed [30:0] lat; logic signed [31:0] lon;
  logic [3:0] fix; logic [6:0] sats; logic [16:0] hdop; logic signed [20:0] alt;

  // Accept a byte whenever the queue has room for the token it may produce.
  assign s_axis_tready = !full;
  assign take = s_axis_tvalid && s_axis_tready;

  ngga_front #(.LINE_MAX(LINE_MAX), .MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)) u_front (
    .clk_i, .rst_ni, .take_i(take), .byte_i(s_axis_tdata), .push_o(push), .tok_o(ftok)
  );

  ngga_fifo u_fifo (
    .clk_i, .rst_ni, .push_i(push), .tok_i(ftok), .full_o(full),
    .pop_i(pop), .valid_o(qvalid), .tok_o(qtok)
  );

  ngga_back #(.MINUTE_FRACTION_DIGITS(MINUTE_FRACTION_DIGITS)) u_back (
    .clk_i, .rst_ni, .in_valid_i(qvalid), .in_tok_i(qtok), .pop_o(pop),
    .out_valid_o(m_axis_tvalid), .out_ready_i(m_axis_tready),
    .utc_hhmmss_o(hhmmss), .utc_millis_o(millis), .latitude_e7_o(lat),
    .longitude_e7_o(lon), .fix_ind_o(fix), .satellite_count_o(sats),
    .hdop_centi_o(hdop), .altitude_dm_o(alt)
  );

  // Pack the record, first field in the low bits.
  assign m_axis_tdata = {4'd0, alt, hdop, sats, fix, lon, lat, millis, hhmmss};

endmodule
`default_nettype wire

// ===== hdl/ngga_checker.sv =====
// Port-level checks for the GGA sentence parser, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
module ngga_checker (
  input wire logic         clk_i,
  input wire logic         rst_ni,
  input wire logic         s_axis_tvalid,
  input wire logic         s_axis_tready,
  input wire logic [7:0]   s_axis_tdata,
  input wire logic         m_axis_tvalid,
  input wire logic         m_axis_tready,
  input wire logic [143:0] m_axis_tdata
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
    else $error("record dropped while stalled");

  a_time_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[17:0] <= 18'd235960) && (m_axis_tdata[27:18] <= 10'd999))
    else $error("time out of range");

  a_small_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tdata[94:91] <= 4'd9) && (m_axis_tdata[101:95] <= 7'd99) &&
                      (m_axis_tdata[118:102] <= 17'd99999))
    else $error("fix, satellites or hdop out of range");

  // Hold the record steady while the consumer stalls.
  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> $stable(m_axis_tdata))
    else $error("record changed while stalled");

endmodule

bind nmea_gga_sentence_parser ngga_checker u_ngga_checker (.*);
`default_nettype wire

// ===== sim/tb_top.sv =====
// Testbench for the NMEA GGA sentence parser: directed sentences, then random traffic.
`timescale 1ns / 1ps
module tb_top;
  import ngga_pkg::*;

  localparam int LINE_MAX  = 128;
  localparam int MIN_FRAC  = 5;
  localparam int HDR_LEN   = 6;
  localparam int HDR_FAIL  = 7;
  localparam int IDLE_LIMIT = 4000;
  localparam int RAND_BYTES = 1250;
  localparam int RAND_RECS  = 20;
  localparam int PH_START = 0, PH_INT = 1, PH_FRAC = 2, PH_STOP = 3;

  typedef struct {
    logic [17:0] hhmmss;
    logic [9:0]  millis;
    logic [30:0] lat;
    logic [31:0] lon;
    logic [3:0]  fix;
    logic [6:0]  sats;
    logic [16:0] hdop;
    logic [20:0] alt;
  } gga_rec_t;

  typedef struct {
    string    text;
    bit       typed;
    gga_rec_t rec;
  } line_row_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [7:0]   s_axis_tdata = 8'h00;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [143:0] m_axis_tdata;

  gga_rec_t  pending_recs[$];
  line_row_t rows[$];
  bit        typed_en = 1'b0;
  gga_rec_t  typed_rec;
  int        errors = 0;
  int        recs_queued = 0;
  int        idle_cycles = 0;
  int        burst_left = 0;

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  nmea_gga_sentence_parser #(
    .LINE_MAX(LINE_MAX),
    .MINUTE_FRACTION_DIGITS(MIN_FRAC)
  ) i_dut (
    .clk_i(clk_i),
    .rst_ni(rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata(s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata)
  );

  // ---------------------------------------------------------------- parser model
  int unsigned ln_len, hdr_st, fld_no, int_acc, frac_acc, frac_cnt, phase;
  bit          neg;
  int unsigned fres[8];
  logic [3:0]  hemi;

  function automatic longint unsigned ten_pow(int unsigned e);
    longint unsigned r;
    r = 1;
    for (int i = 0; i < e; i++) r = r * 10;
    return r;
  endfunction

  function automatic int unsigned frac_keep(int unsigned f);
    case (f)
      FldTime: return 3;
      FldLat, FldLon: return MIN_FRAC;
      FldHdop: return 2;
      FldAlt: return 1;
      default: return 0;
    endcase
  endfunction

  function automatic longint unsigned frac_scaled(int unsigned k);
    int unsigned n;
    n = (frac_cnt > k) ? k : frac_cnt;
    return longint'(frac_acc) * ten_pow(k - n);
  endfunction

  function automatic longint unsigned clip(longint unsigned v, longint unsigned lim);
    return (v > lim) ? lim : v;
  endfunction

  // ddmm.mmmm to 1e-7 degree, minutes rounded half up
  function automatic int unsigned coord_to_e7(longint unsigned lim);
    longint unsigned deg, mins, den, mag;
    deg  = int_acc / 100;
    mins = longint'(int_acc % 100) * ten_pow(MIN_FRAC) + frac_scaled(MIN_FRAC);
    den  = 60 * ten_pow(MIN_FRAC);
    mag  = deg * 64'd10000000 + (mins * 64'd10000000 + den / 2) / den;
    mag  = clip(mag, lim);
    return neg ? (32'd0 - 32'(mag)) : 32'(mag);
  endfunction

  task automatic clear_field();
    int_acc = 0; frac_acc = 0; frac_cnt = 0; phase = PH_START; neg = 0;
  endtask

  task automatic clear_line();
    ln_len = 0; hdr_st = 0; fld_no = 0; hemi = '0;
    foreach (fres[i]) fres[i] = 0;
    clear_field();
  endtask

  task automatic close_field();
    longint unsigned ip, v;
    ip = neg ? 0 : int_acc;
    case (fld_no)
      FldTime: begin
        fres[0] = 32'(clip(ip, 235960));
        fres[1] = neg ? 0 : 32'(frac_scaled(3));
      end
      FldLat: fres[2] = coord_to_e7(900000000);
      FldLon: fres[3] = coord_to_e7(1800000000);
      FldFix: fres[4] = 32'(clip(ip, 9));
      FldSats: fres[5] = 32'(clip(ip, 99));
      FldHdop: begin
        v = ip * 100 + (neg ? 0 : frac_scaled(2));
        fres[6] = 32'(clip(v, 99999));
      end
      FldAlt: begin
        v = longint'(int_acc) * 10 + frac_scaled(1);
        fres[7] = neg ? (32'd0 - 32'(clip(v, 100000))) : 32'(clip(v, 1000000));
      end
      default: ;
    endcase
  endtask

  task automatic feed_char(logic [7:0] c);
    logic [1:0] bits;
    if (fld_no == FldNs || fld_no == FldEw) begin
      if (phase == PH_START) begin
        bits = 2'b00;
        if (c == "N" || c == "E") bits = 2'b01;
        else if (c == "S" || c == "W") bits = 2'b11;
        if (fld_no == FldNs) hemi[1:0] = bits;
        else hemi[3:2] = bits;
        phase = PH_STOP;
      end
    end else if (phase != PH_STOP) begin
      if (c >= "0" && c <= "9") begin
        if (phase == PH_FRAC) begin
          if (frac_cnt < frac_keep(fld_no)) begin
            frac_acc = frac_acc * 10 + (c - "0");
            frac_cnt++;
          end
        end else begin
          int_acc = 32'(clip(longint'(int_acc) * 10 + (c - "0"), 64'hFFFF_FFFF));
          phase = PH_INT;
        end
      end else if (phase == PH_START && (c == "-" || c == "+")) begin
        neg = (c == "-");
        phase = PH_INT;
      end else if (phase <= PH_INT && c == ".") begin
        phase = PH_FRAC;
      end else begin
        phase = PH_STOP;
      end
    end
  endtask

  // Advance the model by one accepted byte; queue a record on a qualifying line end.
  task automatic gga_predict(logic [7:0] c);
    string    hdr;
    int       pos;
    gga_rec_t r;
    int unsigned lat, lon;
    hdr = "$GNGGA";
    if (c == 8'h0D || c == 8'h0A) begin
      if (ln_len != 0) begin
        if (hdr_st == HDR_LEN) begin
          close_field();
          if (fld_no >= 9) begin
            lat = 0; lon = 0;
            if (hemi[0]) lat = hemi[1] ? 32'd0 - fres[2] : fres[2];
            if (hemi[2]) lon = hemi[3] ? 32'd0 - fres[3] : fres[3];
            r.hhmmss = fres[0][17:0];
            r.millis = fres[1][9:0];
            r.lat    = lat[30:0];
            r.lon    = lon;
            r.fix    = fres[4][3:0];
            r.sats   = fres[5][6:0];
            r.hdop   = fres[6][16:0];
            r.alt    = fres[7][20:0];
            pending_recs.push_back(typed_en ? typed_rec : r);
            recs_queued++;
          end
        end
        clear_line();
      end
    end else if (ln_len < LINE_MAX - 1) begin
      pos = ln_len;
      ln_len++;
      if (pos < HDR_LEN) begin
        if (hdr_st == pos)
          hdr_st = (c == hdr[pos] || (pos == 2 && c == "P")) ? pos + 1 : HDR_FAIL;
      end else if (hdr_st == HDR_LEN) begin
        if (c == ",") begin
          close_field();
          if (fld_no < 15) fld_no++;
          clear_field();
        end else begin
          feed_char(c);
        end
      end
    end
  endtask

  // ---------------------------------------------------------------- sender
  // Send one byte; bursts of random length are separated by random gaps.
  task automatic send_byte(logic [7:0] b);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
      burst_left = $urandom_range(1, 40);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    do @(posedge clk_i); while (!s_axis_tready);
    gga_predict(b);
    burst_left--;
  endtask

  task automatic send_text(string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  // Hold the sender until every queued record has come out.
  task automatic drain();
    s_axis_tvalid <= 1'b0;
    burst_left = 0;
    do @(posedge clk_i); while (pending_recs.size() != 0);
  endtask

  // ---------------------------------------------------------------- random lines
  function automatic string rand_num(int max_int, int max_frac, bit may_sign);
    string s;
    int n;
    s = "";
    if (may_sign && $urandom_range(0, 9) == 0) s = ($urandom_range(0, 1) != 0) ? "-" : "+";
    n = $urandom_range(0, max_int);
    for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    if ($urandom_range(0, 3) != 0) begin
      s = {s, "."};
      n = $urandom_range(0, max_frac);
      for (int i = 0; i < n; i++) s = {s, string'(8'("0" + $urandom_range(0, 9)))};
    end
    if ($urandom_range(0, 19) == 0) s = {s, string'(8'($urandom_range(33, 126)))};
    return s;
  endfunction

  function automatic string rand_hemi();
    string opts;
    int k;
    opts = "NSEWXn";
    k = $urandom_range(0, 6);
    return (k == 6) ? "" : string'(opts[k]);
  endfunction

  function automatic string rand_sentence();
    string s, f[9], ends[3];
    int nf;
    ends = '{"\r", "\n", "\r\n"};
    s = ($urandom_range(0, 1) != 0) ? "$GNGGA" : "$GPGGA";
    if ($urandom_range(0, 14) == 0) s[$urandom_range(0, 5)] = 8'($urandom_range(33, 126));
    f[0] = rand_num(7, 5, 1);
    f[1] = rand_num(5, 7, 1);
    f[2] = rand_hemi();
    f[3] = rand_num(6, 7, 1);
    f[4] = rand_hemi();
    f[5] = rand_num(2, 1, 1);
    f[6] = rand_num(3, 1, 1);
    f[7] = rand_num(5, 3, 1);
    f[8] = rand_num(8, 3, 1);
    nf = ($urandom_range(0, 14) == 0) ? $urandom_range(0, 8) : 9;
    for (int i = 0; i < nf; i++) s = {s, ",", f[i]};
    if ($urandom_range(0, 2) == 0) s = {s, ",M,46.9,M,,*47"};
    if ($urandom_range(0, 24) == 0)
      for (int i = 0; i < 120; i++) s = {s, "7"};
    return {s, ends[$urandom_range(0, 2)]};
  endfunction

  // ---------------------------------------------------------------- receiver and checks
  function automatic gga_rec_t unpack_rec(logic [143:0] d);
    gga_rec_t r;
    r.hhmmss = d[17:0];
    r.millis = d[27:18];
    r.lat    = d[58:28];
    r.lon    = d[90:59];
    r.fix    = d[94:91];
    r.sats   = d[101:95];
    r.hdop   = d[118:102];
    r.alt    = d[139:119];
    return r;
  endfunction

  function automatic void check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
    if (exp_v !== act_v) begin
      errors++;
      if (errors <= 10)
        $display("mismatch %s: expected %0h, got %0h", name, exp_v, act_v);
    end
  endfunction

  int       rdy_cnt = 0;
  int       rdy_mode = 0;
  gga_rec_t got, want;

  always @(posedge clk_i) begin
    if (m_axis_tvalid && m_axis_tready) begin
      got = unpack_rec(m_axis_tdata);
      if (pending_recs.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected record %h", m_axis_tdata);
      end else begin
        want = pending_recs.pop_front();
        check_field("utc_hhmmss", 32'(want.hhmmss), 32'(got.hhmmss));
        check_field("utc_millis", 32'(want.millis), 32'(got.millis));
        check_field("latitude_e7", 32'(want.lat), 32'(got.lat));
        check_field("longitude_e7", want.lon, got.lon);
        check_field("fix_ind", 32'(want.fix), 32'(got.fix));
        check_field("satellite_count", 32'(want.sats), 32'(got.sats));
        check_field("hdop_centi", 32'(want.hdop), 32'(got.hdop));
        check_field("altitude_dm", 32'(want.alt), 32'(got.alt));
      end
    end
    rdy_cnt <= rdy_cnt + 1;
    if (rdy_cnt % 300 == 299) rdy_mode <= $urandom_range(0, 3);
    case (rdy_mode)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ($urandom_range(0, 1) != 0);
      2: m_axis_tready <= (rdy_cnt % 4 == 0);
      default: m_axis_tready <= (rdy_cnt % 64 < 8);
    endcase
  end

  // Watchdog: abort when nothing moves on either side for too long.
  always @(posedge clk_i) begin
    if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= IDLE_LIMIT) begin
      $display("tb_top NOT OK");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  // ---------------------------------------------------------------- stimulus
  function automatic void add_row(string s, bit typed, gga_rec_t r);
    line_row_t row;
    row.text = s; row.typed = typed; row.rec = r;
    rows.push_back(row);
  endfunction

  initial begin
    gga_rec_t z, mx, lo;
    string longl;
    int sent;
    z  = '{default: '0};
    mx = '{hhmmss: 235960, millis: 999, lat: 900000000, lon: 1800000000,
           fix: 9, sats: 99, hdop: 99999, alt: 1000000};
    lo = '{hhmmss: 1, millis: 0, lat: 0, lon: 0, fix: 0, sats: 0, hdop: 0,
           alt: 21'(-100000)};
    longl = "$GNGGA,1,2,N,3,E,4,5,6,";
    for (int i = 0; i < 150; i++) longl = {longl, "1"};

    add_row("\r\n\n", 0, z);
    add_row("$GPGGA,235960.999,9000.00000,N,18000.00000,E,9,99,999.99,100000.0\r", 1, mx);
    add_row("$GNGGA,,,,,,,,,\n", 1, z);
    add_row("$GPGGA,1,0000.00000,S,0,W,0,0,0,-99999999\r", 1, lo);
    add_row("$GNGGA,123519.5,4807.038,N,01131.000,E,1,08,0.9,545.4,M,46.9,M,,*47\r\n", 0, z);
    add_row("$GPGGA,-1,4530.5,S,12230.25,W,-3,+7,-1.5,-20000.5\n", 0, z);
    add_row("$GNGGA,99999999999,9999.99999,X,99999.999999,,12,100,1000.001,99999.99\r",
            0, z);
    add_row("$GNGGA,1a2,12.3.4,n,+5,w,..,x,1e2,+\r", 0, z);
    add_row("$GNGGA,4294967296,-9000.5,S,-18000.000005,W,+,-,.,-.\r", 0, z);
    add_row("$GPGGA,1,2,N,3,E,4,5,6\r", 0, z);
    add_row("$GPRMC,1,2,3,4,5,6,7,8,9\r", 0, z);
    add_row("$GNGG\r", 0, z);
    add_row("$GNGGA\n", 0, z);
    add_row("X$GNGGA,1,2,N,3,E,4,5,6,7\r", 0, z);
    add_row("$GNGGA,,,,,,,,,,,,,,,,,,,,,5\n", 0, z);
    add_row({longl, "\r"}, 0, z);
    add_row("$GPGGA,000000.1,0030.00001,E,00000.000005,N,0,0,0.01,-0.05\r", 0, z);

    clear_line();
    repeat (2) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed sentences; hand-computed records where they are obvious.
    foreach (rows[i]) begin
      typed_en  = rows[i].typed;
      typed_rec = rows[i].rec;
      send_text(rows[i].text);
      typed_en = 1'b0;
    end
    drain();

    // Random traffic: mostly well-formed sentences, some noise lines.
    sent = 0;
    while (sent < RAND_BYTES || recs_queued < RAND_RECS) begin
      string s;
      int n;
      if ($urandom_range(0, 9) == 0) begin
        n = $urandom_range(1, 40);
        for (int i = 0; i < n; i++) send_byte(8'($urandom_range(0, 255)));
        sent += n;
      end else begin
        s = rand_sentence();
        send_text(s);
        sent += s.len();
      end
      if ($urandom_range(0, 15) == 0) drain();
    end

    // Flush the end of the stream and let the pipeline settle.
    drain();
    repeat (20) @(posedge clk_i);
    if (errors == 0 && pending_recs.size() == 0)
      $display("tb_top OK");
    else
      $display("tb_top NOT OK");
    $finish;
  end

endmodule
